// ----- design/ddt_pkg.sv -----
// Shared types, constants and helpers of the detection dedup table.
// Used by every module of the block; depends on nothing.
package ddt_pkg;

    localparam int TABLE_DEPTH  = 16;
    localparam int FRAME_DEPTH  = 16;
    localparam int COORD_BITS   = 16;
    localparam int RESULT_LIMIT = 16;

    localparam int LABEL_W  = 8;
    localparam int FIELD_W  = 16;
    localparam int Q_BITS   = 16;
    localparam int AREA_W   = 2 * COORD_BITS;
    localparam int SUM_W    = AREA_W + 1;
    localparam int PROD_W   = SUM_W + Q_BITS;

    localparam int IDX_W    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int FIDX_W   = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;
    localparam int QIDX_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CNT_W    = $clog2(FRAME_DEPTH + 1);
    localparam int RES_W    = $clog2(RESULT_LIMIT + 1);
    localparam int SCAN_W   = (TABLE_DEPTH > FRAME_DEPTH) ? $clog2(TABLE_DEPTH + 1)
                                                          : $clog2(FRAME_DEPTH + 1);

    localparam int IN_DATA_W  = 80;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_IDX_W  = 2;

    localparam logic [15:0] IOU_THR_RST   = 16'd62259;
    localparam logic [7:0]  RETENTION_RST = 8'd5;
    localparam logic [15:0] REP_DIST_RST  = 16'd1475;
    localparam logic [7:0]  AGE_MAX       = 8'hFF;

    typedef enum logic [1:0] {
        CMD_PRE   = 2'd0,
        CMD_ZS    = 2'd1,
        CMD_TICK  = 2'd2,
        CMD_QUERY = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        STAT_INSERTED  = 3'd0,
        STAT_REPLACED  = 3'd1,
        STAT_REPEATED  = 3'd2,
        STAT_FULL      = 3'd3,
        STAT_TICK_DONE = 3'd4,
        STAT_ENTRY     = 3'd5,
        STAT_NONE      = 3'd6
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IOU_THR   = 2'd0,
        REG_RETENTION = 2'd1,
        REG_REP_DIST  = 2'd2
    } t_reg_idx;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIST,
        S_IOU,
        S_EMIT,
        S_QUERY
    } t_state;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_cmd                cmd;
        logic [LABEL_W-1:0]  label;
        logic                all;
        logic                fstart;
        t_coord [3:0]        box;
        t_coord              cx;
        t_coord              cy;
        logic [AREA_W-1:0]   area;
    } t_job;

    typedef struct packed {
        logic [15:0] iou_thr;
        logic [7:0]  retention;
        logic [15:0] rep_dist;
    } t_cfg;

    function automatic t_coord span(input t_coord lo, input t_coord hi);
        span = (hi > lo) ? t_coord'(hi - lo) : '0;
    endfunction

endpackage

// ----- design/ddt_front.sv -----
// Front end: takes input words, unpacks and classifies them into jobs.
// Precomputes centroid and box area. Depends on ddt_pkg.
module ddt_front (
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic [ddt_pkg::IN_DATA_W-1:0]          i_data,
    input  logic [1:0]                             i_user,
    input  logic                                   i_full,
    output logic                                   o_push,
    output ddt_pkg::t_job                          o_job
);

    ddt_pkg::t_coord [3:0]              w_box;
    logic [ddt_pkg::COORD_BITS:0]       w_sx;
    logic [ddt_pkg::COORD_BITS:0]       w_sy;
    ddt_pkg::t_coord                    w_w;
    ddt_pkg::t_coord                    w_h;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        w_box[0] = i_data[10 +: ddt_pkg::COORD_BITS];
        w_box[1] = i_data[26 +: ddt_pkg::COORD_BITS];
        w_box[2] = i_data[42 +: ddt_pkg::COORD_BITS];
        w_box[3] = i_data[58 +: ddt_pkg::COORD_BITS];
        w_sx = {1'b0, w_box[0]} + {1'b0, w_box[2]};
        w_sy = {1'b0, w_box[1]} + {1'b0, w_box[3]};
        w_w  = ddt_pkg::span(w_box[0], w_box[2]);
        w_h  = ddt_pkg::span(w_box[1], w_box[3]);

        o_job.cmd    = ddt_pkg::t_cmd'(i_user);
        o_job.label  = i_data[7:0];
        o_job.all    = i_data[8];
        o_job.fstart = i_data[9];
        o_job.box    = w_box;
        o_job.cx     = w_sx[ddt_pkg::COORD_BITS:1];
        o_job.cy     = w_sy[ddt_pkg::COORD_BITS:1];
        o_job.area   = w_w * w_h;
    end

endmodule

// ----- design/ddt_fifo.sv -----
// Two-entry job queue between the front end and the table engine.
// Depends on ddt_pkg for the job type.
module ddt_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ddt_pkg::t_job  i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output ddt_pkg::t_job  o_job
);

    ddt_pkg::t_job r_mem [2];
    logic          r_wp;
    logic          r_rp;
    logic [1:0]    r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

// ----- design/ddt_engine.sv -----
// Table engine: holds slots and frame centroids, runs IoU and distance
// scans through a three-stage pipe, and drives the registered result word.
// Depends on ddt_pkg.
module ddt_engine (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ddt_pkg::t_cfg                      i_cfg,
    input  logic                               i_job_valid,
    input  ddt_pkg::t_job                      i_job,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output ddt_pkg::t_status                   o_status,
    output logic [ddt_pkg::LABEL_W-1:0]        o_label,
    output logic [3:0][ddt_pkg::FIELD_W-1:0]   o_box,
    output logic                               o_last
);

    localparam int TD = ddt_pkg::TABLE_DEPTH;
    localparam int FD = ddt_pkg::FRAME_DEPTH;
    localparam int C  = ddt_pkg::COORD_BITS;

    // table and frame storage
    logic [TD-1:0]                 r_valid;
    logic [ddt_pkg::LABEL_W-1:0]   r_slabel [TD];
    ddt_pkg::t_coord [3:0]         r_sbox   [TD];
    logic [7:0]                    r_age    [TD];
    ddt_pkg::t_coord               r_cx     [FD];
    ddt_pkg::t_coord               r_cy     [FD];
    logic [ddt_pkg::CNT_W-1:0]     r_ccount;

    ddt_pkg::t_state  r_state, n_state;
    ddt_pkg::t_job    r_job;
    ddt_pkg::t_status r_res, n_res;

    // scan pipe
    logic [ddt_pkg::SCAN_W-1:0]    r_iss;
    logic                          r_p1v, r_p2v, r_p3v;
    logic                          r_p1ok, r_p2ok, r_p3ok;
    logic [ddt_pkg::SCAN_W-1:0]    r_p1i, r_p2i, r_p3i;
    ddt_pkg::t_coord               r_p1a, r_p1b, r_p1c, r_p1d;
    logic [ddt_pkg::AREA_W-1:0]    r_p2x, r_p2y, r_p3y;
    logic [ddt_pkg::SUM_W-1:0]     r_p3s;
    logic                          r_hit;
    logic [ddt_pkg::SCAN_W-1:0]    r_hit_idx;

    // query walk
    logic [ddt_pkg::QIDX_W-1:0]    r_qidx;
    logic [ddt_pkg::RES_W-1:0]     r_qn;

    // result register
    logic                          r_ov;
    ddt_pkg::t_status              r_ostat;
    logic [ddt_pkg::LABEL_W-1:0]   r_olabel;
    ddt_pkg::t_coord [3:0]         r_obox;
    logic                          r_olast;

    logic                          can_emit;
    logic                          issue;
    logic                          scan_end;
    logic                          scan_rst;
    logic                          commit;
    logic                          load_status;
    logic                          load_entry;
    logic                          q_last;
    logic                          q_adv;
    logic                          hit_now;
    logic [ddt_pkg::SCAN_W-1:0]    limit;
    logic [ddt_pkg::IDX_W-1:0]     sidx;
    logic [ddt_pkg::FIDX_W-1:0]    fidx;
    logic [ddt_pkg::IDX_W-1:0]     qsel;
    logic [ddt_pkg::IDX_W-1:0]     hsel;
    logic [ddt_pkg::IDX_W-1:0]     free_idx;
    logic                          free_any;
    logic [TD-1:0]                 qmvec;
    logic                          qmatch;
    logic                          more;
    logic                          is_dist;
    ddt_pkg::t_coord               ix0, iy0, ix1, iy1;
    ddt_pkg::t_coord               dx, dy;
    logic [ddt_pkg::PROD_W-1:0]    thr_prod;
    logic [ddt_pkg::PROD_W-1:0]    lhs;
    logic [ddt_pkg::PROD_W-1:0]    rhs;
    logic [ddt_pkg::FIDX_W-1:0]    cwr;

    assign can_emit = !r_ov || i_ready;
    assign is_dist  = (r_state == ddt_pkg::S_DIST);
    assign limit    = is_dist ? ddt_pkg::SCAN_W'(r_ccount) : ddt_pkg::SCAN_W'(TD);
    assign issue    = (r_state == ddt_pkg::S_DIST || r_state == ddt_pkg::S_IOU)
                      && (r_iss < limit);
    assign scan_end = (r_iss == limit) && !r_p1v && !r_p2v && !r_p3v;
    assign sidx     = r_iss[ddt_pkg::IDX_W-1:0];
    assign fidx     = r_iss[ddt_pkg::FIDX_W-1:0];
    assign qsel     = r_qidx[ddt_pkg::IDX_W-1:0];
    assign hsel     = r_hit_idx[ddt_pkg::IDX_W-1:0];

    // lowest free slot and query matches
    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = TD - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = ddt_pkg::IDX_W'(i);
            end
        end
        for (int i = 0; i < TD; i++) begin
            qmvec[i] = r_valid[i] && (r_job.all || r_slabel[i] == r_job.label);
        end
        more = 1'b0;
        for (int i = 0; i < TD; i++) begin
            if (ddt_pkg::QIDX_W'(i) > r_qidx && qmvec[i]) begin
                more = 1'b1;
            end
        end
        qmatch = (r_qidx < ddt_pkg::QIDX_W'(TD)) && qmvec[qsel];
        q_last = !more || (r_qn == ddt_pkg::RES_W'(ddt_pkg::RESULT_LIMIT - 1));
    end

    // first pipe stage operands
    always_comb begin
        ix0 = (r_sbox[sidx][0] > r_job.box[0]) ? r_sbox[sidx][0] : r_job.box[0];
        iy0 = (r_sbox[sidx][1] > r_job.box[1]) ? r_sbox[sidx][1] : r_job.box[1];
        ix1 = (r_sbox[sidx][2] < r_job.box[2]) ? r_sbox[sidx][2] : r_job.box[2];
        iy1 = (r_sbox[sidx][3] < r_job.box[3]) ? r_sbox[sidx][3] : r_job.box[3];
        dx  = (r_job.cx > r_cx[fidx]) ? ddt_pkg::t_coord'(r_job.cx - r_cx[fidx])
                                      : ddt_pkg::t_coord'(r_cx[fidx] - r_job.cx);
        dy  = (r_job.cy > r_cy[fidx]) ? ddt_pkg::t_coord'(r_job.cy - r_cy[fidx])
                                      : ddt_pkg::t_coord'(r_cy[fidx] - r_job.cy);
    end

    // last stage: compare
    always_comb begin
        thr_prod = ddt_pkg::PROD_W'(i_cfg.iou_thr) * ddt_pkg::PROD_W'(r_p3s);
        if (is_dist) begin
            lhs     = {r_p3s, {ddt_pkg::Q_BITS{1'b0}}};
            rhs     = ddt_pkg::PROD_W'({i_cfg.rep_dist, {(2 * C){1'b0}}});
            hit_now = r_p3v && (lhs < rhs);
        end else begin
            lhs     = ddt_pkg::PROD_W'({r_p3y, {ddt_pkg::Q_BITS{1'b0}}});
            rhs     = thr_prod;
            hit_now = r_p3v && r_p3ok && (r_p3s != '0) && (lhs > rhs);
        end
    end

    // control
    always_comb begin
        n_state     = r_state;
        n_res       = r_res;
        o_pop       = 1'b0;
        scan_rst    = 1'b0;
        commit      = 1'b0;
        load_status = 1'b0;
        load_entry  = 1'b0;
        q_adv       = 1'b0;
        unique case (r_state)
            ddt_pkg::S_IDLE: begin
                if (i_job_valid) begin
                    o_pop    = 1'b1;
                    scan_rst = 1'b1;
                    unique case (i_job.cmd)
                        ddt_pkg::CMD_PRE: n_state = ddt_pkg::S_IOU;
                        ddt_pkg::CMD_ZS: begin
                            n_state = (r_ccount == '0) ? ddt_pkg::S_IOU : ddt_pkg::S_DIST;
                        end
                        ddt_pkg::CMD_TICK: begin
                            n_state = ddt_pkg::S_EMIT;
                            n_res   = ddt_pkg::STAT_TICK_DONE;
                        end
                        ddt_pkg::CMD_QUERY: n_state = ddt_pkg::S_QUERY;
                    endcase
                end
            end
            ddt_pkg::S_DIST: begin
                if (scan_end) begin
                    if (r_hit) begin
                        n_state = ddt_pkg::S_EMIT;
                        n_res   = ddt_pkg::STAT_REPEATED;
                    end else begin
                        n_state  = ddt_pkg::S_IOU;
                        scan_rst = 1'b1;
                    end
                end
            end
            ddt_pkg::S_IOU: begin
                if (scan_end) begin
                    commit  = 1'b1;
                    n_state = ddt_pkg::S_EMIT;
                    if (r_hit) begin
                        n_res = ddt_pkg::STAT_REPLACED;
                    end else if (free_any) begin
                        n_res = ddt_pkg::STAT_INSERTED;
                    end else begin
                        n_res = ddt_pkg::STAT_FULL;
                    end
                end
            end
            ddt_pkg::S_EMIT: begin
                if (can_emit) begin
                    load_status = 1'b1;
                    n_state     = ddt_pkg::S_IDLE;
                end
            end
            ddt_pkg::S_QUERY: begin
                if (r_qidx == ddt_pkg::QIDX_W'(TD)) begin
                    if (r_qn == '0) begin
                        n_state = ddt_pkg::S_EMIT;
                        n_res   = ddt_pkg::STAT_NONE;
                    end else begin
                        n_state = ddt_pkg::S_IDLE;
                    end
                end else if (!qmatch) begin
                    q_adv = 1'b1;
                end else if (can_emit) begin
                    load_entry = 1'b1;
                    q_adv      = 1'b1;
                    if (q_last) begin
                        n_state = ddt_pkg::S_IDLE;
                    end
                end
            end
            default: n_state = ddt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ddt_pkg::S_IDLE;
            r_res   <= ddt_pkg::STAT_INSERTED;
        end else begin
            r_state <= n_state;
            r_res   <= n_res;
        end
    end

    // scan pipe control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iss <= '0;
            r_p1v <= 1'b0;
            r_p2v <= 1'b0;
            r_p3v <= 1'b0;
            r_hit <= 1'b0;
        end else if (scan_rst) begin
            r_iss <= '0;
            r_p1v <= 1'b0;
            r_p2v <= 1'b0;
            r_p3v <= 1'b0;
            r_hit <= 1'b0;
        end else begin
            if (issue) begin
                r_iss <= r_iss + 1'b1;
            end
            r_p1v <= issue;
            r_p2v <= r_p1v;
            r_p3v <= r_p2v;
            if (hit_now && !r_hit) begin
                r_hit <= 1'b1;
            end
        end
    end

    // scan pipe data
    always_ff @(posedge i_clk) begin
        r_p1i <= r_iss;
        if (is_dist) begin
            r_p1ok <= 1'b1;
            r_p1a  <= dx;
            r_p1b  <= dx;
            r_p1c  <= dy;
            r_p1d  <= dy;
        end else begin
            r_p1ok <= r_valid[sidx] && (r_slabel[sidx] == r_job.label);
            r_p1a  <= ddt_pkg::span(r_sbox[sidx][0], r_sbox[sidx][2]);
            r_p1b  <= ddt_pkg::span(r_sbox[sidx][1], r_sbox[sidx][3]);
            r_p1c  <= ddt_pkg::span(ix0, ix1);
            r_p1d  <= ddt_pkg::span(iy0, iy1);
        end
        r_p2i  <= r_p1i;
        r_p2ok <= r_p1ok;
        r_p2x  <= r_p1a * r_p1b;
        r_p2y  <= r_p1c * r_p1d;
        r_p3i  <= r_p2i;
        r_p3ok <= r_p2ok;
        r_p3y  <= r_p2y;
        if (is_dist) begin
            r_p3s <= ddt_pkg::SUM_W'(r_p2x) + ddt_pkg::SUM_W'(r_p2y);
        end else begin
            r_p3s <= ddt_pkg::SUM_W'(r_p2x) + ddt_pkg::SUM_W'(r_job.area)
                     - ddt_pkg::SUM_W'(r_p2y);
        end
        if (hit_now && !r_hit) begin
            r_hit_idx <= r_p3i;
        end
    end

    // job latch and query walk
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qidx <= '0;
            r_qn   <= '0;
        end else if (o_pop) begin
            r_qidx <= '0;
            r_qn   <= '0;
        end else begin
            if (q_adv) begin
                r_qidx <= r_qidx + 1'b1;
            end
            if (load_entry) begin
                r_qn <= r_qn + 1'b1;
            end
        end
    end

    // valid bits, ages and centroid count
    assign cwr = (i_job.fstart) ? '0 : r_ccount[ddt_pkg::FIDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_ccount <= '0;
        end else begin
            if (o_pop && i_job.cmd == ddt_pkg::CMD_PRE) begin
                if (i_job.fstart) begin
                    r_ccount <= ddt_pkg::CNT_W'(1);
                end else if (r_ccount < ddt_pkg::CNT_W'(FD)) begin
                    r_ccount <= r_ccount + 1'b1;
                end
            end
            if (o_pop && i_job.cmd == ddt_pkg::CMD_TICK) begin
                for (int i = 0; i < TD; i++) begin
                    if (r_valid[i]) begin
                        if (r_age[i] == ddt_pkg::AGE_MAX) begin
                            r_valid[i] <= (ddt_pkg::AGE_MAX <= i_cfg.retention);
                        end else begin
                            r_valid[i] <= ((r_age[i] + 8'd1) <= i_cfg.retention);
                        end
                    end
                end
            end
            if (commit && !r_hit && free_any) begin
                r_valid[free_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_job.cmd == ddt_pkg::CMD_PRE
            && (i_job.fstart || r_ccount < ddt_pkg::CNT_W'(FD))) begin
            r_cx[cwr] <= i_job.cx;
            r_cy[cwr] <= i_job.cy;
        end
        if (o_pop && i_job.cmd == ddt_pkg::CMD_TICK) begin
            for (int i = 0; i < TD; i++) begin
                if (r_valid[i] && r_age[i] != ddt_pkg::AGE_MAX) begin
                    r_age[i] <= r_age[i] + 8'd1;
                end
            end
        end
        if (commit) begin
            if (r_hit) begin
                r_sbox[hsel] <= r_job.box;
                r_age[hsel]  <= '0;
            end else if (free_any) begin
                r_sbox[free_idx]   <= r_job.box;
                r_slabel[free_idx] <= r_job.label;
                r_age[free_idx]    <= '0;
            end
        end
    end

    // result register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (load_status || load_entry) begin
            r_ov <= 1'b1;
        end else if (i_ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_status) begin
            r_ostat  <= r_res;
            r_olabel <= '0;
            r_obox   <= '0;
            r_olast  <= 1'b1;
        end else if (load_entry) begin
            r_ostat  <= ddt_pkg::STAT_ENTRY;
            r_olabel <= r_slabel[qsel];
            r_obox   <= r_sbox[qsel];
            r_olast  <= q_last;
        end
    end

    assign o_valid  = r_ov;
    assign o_status = r_ostat;
    assign o_label  = r_olabel;
    assign o_last   = r_olast;
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            o_box[k] = ddt_pkg::FIELD_W'(r_obox[k]);
        end
    end

endmodule

// ----- design/detection_dedup_table.sv -----
// Detection dedup table. Detections run serial scans through the three-stage
// IoU/distance pipe: zero-shot first over frame centroids (when any), then over
// slots; pretrained over slots only.
// Query: one word per matching slot, at most RESULT_LIMIT, each held until taken.
// Jobs are handled one at a time; the two-entry queue buffers input meanwhile.
// Reset (sync, active low) clears slot valid bits, centroid count and queue, loads config defaults.
module detection_dedup_table (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // label[7:0], query_all[8], frame_start[9], box_xmin, box_ymin,
    // box_xmax, box_ymax (16 bits each from bit 10), zero pad to 80
    input  logic [ddt_pkg::IN_DATA_W-1:0]     i_s_axis_tdata,
    // command[1:0]
    input  logic [1:0]                        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // entry_label[7:0], out_xmin, out_ymin, out_xmax, out_ymax (16 bits each)
    output logic [ddt_pkg::OUT_DATA_W-1:0]    o_m_axis_tdata,
    // status[2:0]
    output logic [2:0]                        o_m_axis_tuser,
    output logic                              o_m_axis_tlast,
    input  logic                              i_cfg_we,
    input  logic [ddt_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [15:0]                       i_cfg_data
);

    ddt_pkg::t_cfg                             r_cfg;
    ddt_pkg::t_job                             front_job;
    ddt_pkg::t_job                             q_job;
    logic                                      push;
    logic                                      full;
    logic                                      q_valid;
    logic                                      pop;
    ddt_pkg::t_status                          status;
    logic [ddt_pkg::LABEL_W-1:0]               label;
    logic [3:0][ddt_pkg::FIELD_W-1:0]          box;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.iou_thr   <= ddt_pkg::IOU_THR_RST;
            r_cfg.retention <= ddt_pkg::RETENTION_RST;
            r_cfg.rep_dist  <= ddt_pkg::REP_DIST_RST;
        end else if (i_cfg_we) begin
            case (ddt_pkg::t_reg_idx'(i_cfg_idx))
                ddt_pkg::REG_IOU_THR:   r_cfg.iou_thr   <= i_cfg_data;
                ddt_pkg::REG_RETENTION: r_cfg.retention <= i_cfg_data[7:0];
                ddt_pkg::REG_REP_DIST:  r_cfg.rep_dist  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    ddt_front u_front (
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .i_user  (i_s_axis_tuser),
        .i_full  (full),
        .o_push  (push),
        .o_job   (front_job)
    );

    ddt_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    ddt_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_status    (status),
        .o_label     (label),
        .o_box       (box),
        .o_last      (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = status;
    assign o_m_axis_tdata = {box[3], box[2], box[1], box[0], label};

endmodule
